// ----- rtl/rvg_pkg.sv -----
// Types and constants shared by the radial vignette gain block.
`timescale 1ns / 1ps
`default_nettype none
package rvg_pkg;

  localparam int unsigned CHAN_W   = 16;
  localparam int unsigned COORD_W  = 12;
  localparam int unsigned DIM_W    = 13;
  localparam int unsigned IN_W     = 2 * COORD_W + 3 * CHAN_W;
  localparam int unsigned OUT_W    = 3 * CHAN_W;
  localparam int unsigned CFG_IDX_W = 3;
  localparam int unsigned CFG_DAT_W = 13;
  localparam int unsigned DEN_W    = 26;
  localparam int unsigned NUM_STAGES = 40;

  localparam logic [DIM_W-1:0] MAX_DIM     = 13'd4096;
  localparam logic [28:0]      RECIP_10K   = 29'd439804652;
  localparam logic [24:0]      RECIP_100   = 25'd21474837;
  localparam logic [22:0]      GAIN_ONE    = 23'd3276800;
  localparam logic [16:0]      SMOOTH_3    = 17'd98304;
  localparam logic [15:0]      W_FULL      = 16'd32768;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_IMG_W    = 3'd0,
    CFG_IMG_H    = 3'd1,
    CFG_MIDPOINT = 3'd2,
    CFG_FEATHER  = 3'd3,
    CFG_AMOUNT   = 3'd4
  } cfg_reg_e;

  typedef struct packed {
    logic [CHAN_W-1:0] blue;
    logic [CHAN_W-1:0] green;
    logic [CHAN_W-1:0] red;
  } rgb_t;

endpackage
`default_nettype wire

// ----- rtl/radial_vignette_gain.sv -----
// Radial vignette gain: smoothstep falloff pipeline, one pixel per clock unless the output stalls.
// Throughput one beat per cycle while the output beat is taken or the output register is empty.
// Whole pipeline advances together when the output register is empty or taken.
// Distance divide (2 bits per stage), square root (2 bits per stage) and weight divide set depth.
// Reset clears valid bits and loads 1024, 1024, 50, 50, 0 into the registers.
`timescale 1ns / 1ps
`default_nettype none
module radial_vignette_gain (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         s_axis_tvalid,
  output logic                         s_axis_tready,
  // col, row_index, red_in, green_in, blue_in
  input  logic [rvg_pkg::IN_W-1:0]     s_axis_tdata,
  output logic                         m_axis_tvalid,
  input  logic                         m_axis_tready,
  // red_out, green_out, blue_out
  output logic [rvg_pkg::OUT_W-1:0]    m_axis_tdata,
  input  logic                         cfg_valid_i,
  output logic                         cfg_ready_o,
  input  logic [rvg_pkg::CFG_IDX_W-1:0] cfg_index_i,
  input  logic [rvg_pkg::CFG_DAT_W-1:0] cfg_data_i
);
  import rvg_pkg::*;

  localparam int unsigned NS = NUM_STAGES;

  function automatic logic [DEN_W:0] div_step(input logic [DEN_W-1:0] rem,
                                              input logic [DEN_W-1:0] den);
    logic [DEN_W:0] r2;
    logic [DEN_W:0] df;
    r2 = {rem, 1'b0};
    df = r2 - {1'b0, den};
    if (r2 >= {1'b0, den}) begin
      div_step = {df[DEN_W-1:0], 1'b1};
    end else begin
      div_step = {r2[DEN_W-1:0], 1'b0};
    end
  endfunction

  function automatic logic [34:0] sq_step(input logic [18:0] rem, input logic [15:0] root,
                                          input logic [1:0] bits);
    logic [18:0] r;
    logic [18:0] trial;
    r = {rem[16:0], bits};
    trial = {1'b0, root, 2'b01};
    if (r >= trial) begin
      sq_step = {r - trial, root[14:0], 1'b1};
    end else begin
      sq_step = {r, root[14:0], 1'b0};
    end
  endfunction

  logic [DIM_W-1:0] img_w_q, img_h_q;
  logic [6:0]       mid_q, fea_q;
  logic [7:0]       amt_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      img_w_q <= 13'd1024;
      img_h_q <= 13'd1024;
      mid_q   <= 7'd50;
      fea_q   <= 7'd50;
      amt_q   <= 8'd0;
    end else if (cfg_valid_i) begin
      case (cfg_reg_e'(cfg_index_i))
        CFG_IMG_W:    img_w_q <= cfg_data_i;
        CFG_IMG_H:    img_h_q <= cfg_data_i;
        CFG_MIDPOINT: mid_q   <= cfg_data_i[6:0];
        CFG_FEATHER:  fea_q   <= cfg_data_i[6:0];
        CFG_AMOUNT:   amt_q   <= cfg_data_i[7:0];
        default: ;
      endcase
    end
  end

  logic [DIM_W-1:0] dw_d, dh_d;
  logic [6:0]       mpc_d, fpc_d;
  logic [13:0]      osum_d;
  logic [DEN_W-1:0] den_q;
  logic [13:0]      on_in_q, on_out_q;
  logic [15:0]      inner_q, outer_q, dif_q;
  logic signed [7:0] amtc_q;
  logic [42:0]      in_prod_d, out_prod_d;

  assign dw_d  = (img_w_q > MAX_DIM) ? MAX_DIM : img_w_q;
  assign dh_d  = (img_h_q > MAX_DIM) ? MAX_DIM : img_h_q;
  assign mpc_d = (mid_q > 7'd99) ? 7'd99 : mid_q;
  assign fpc_d = (fea_q > 7'd100) ? 7'd100 : fea_q;
  assign osum_d = 14'(mpc_d * 14'd100) + ({7'd0, fpc_d} * {7'd0, 7'd100 - mpc_d})
                + 14'd100;
  assign in_prod_d  = {29'd0, on_in_q} * {14'd0, RECIP_10K};
  assign out_prod_d = {29'd0, on_out_q} * {14'd0, RECIP_10K};

  always_ff @(posedge clk_i) begin
    den_q    <= {13'd0, dw_d} * {13'd0, dw_d} + {13'd0, dh_d} * {13'd0, dh_d};
    on_in_q  <= 14'(mpc_d * 14'd100);
    on_out_q <= (osum_d > 14'd10000) ? 14'd10000 : osum_d;
    inner_q  <= in_prod_d[42:27];
    outer_q  <= out_prod_d[42:27];
    dif_q    <= outer_q - inner_q;
    if ($signed(amt_q) > 8'sd100) begin
      amtc_q <= 8'sd100;
    end else if ($signed(amt_q) < -8'sd100) begin
      amtc_q <= -8'sd100;
    end else begin
      amtc_q <= $signed(amt_q);
    end
  end

  logic adv;
  logic [NS-1:0] vld_q;
  logic [NS-2:0] byp_q;
  rgb_t rgb_q [NS-1];

  assign adv = !vld_q[NS-1] || m_axis_tready;
  assign s_axis_tready = adv;
  assign m_axis_tvalid = vld_q[NS-1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (adv) begin
      vld_q <= {vld_q[NS-2:0], s_axis_tvalid};
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      rgb_q[0] <= s_axis_tdata[IN_W-1:2*COORD_W];
      byp_q[0] <= (img_w_q == '0) || (img_h_q == '0);
      for (int i = 1; i < NS - 1; i++) begin
        rgb_q[i] <= rgb_q[i-1];
        byp_q[i] <= byp_q[i-1];
      end
    end
  end

  // Stage 0: squared distance in half-pixels
  logic signed [13:0] dx_d, dy_d;
  logic [12:0] ax_d, ay_d;
  logic [26:0] num_q;

  assign dx_d = $signed({1'b0, s_axis_tdata[COORD_W-1:0], 1'b0}) - $signed({1'b0, dw_d});
  assign dy_d = $signed({1'b0, s_axis_tdata[2*COORD_W-1:COORD_W], 1'b0})
              - $signed({1'b0, dh_d});
  assign ax_d = dx_d[13] ? 13'(-dx_d) : dx_d[12:0];
  assign ay_d = dy_d[13] ? 13'(-dy_d) : dy_d[12:0];

  always_ff @(posedge clk_i) begin
    if (adv) begin
      num_q <= {14'd0, ax_d} * {14'd0, ax_d} + {14'd0, ay_d} * {14'd0, ay_d};
    end
  end

  // Stage 1: saturation and integer part of the ratio
  logic             sat_q     [1:24];
  logic [DEN_W-1:0] div_rem_q [1:16];
  logic [31:0]      div_quo_q [1:16];
  logic [27:0] n28_d, d1_d, d2_d, d4_d, r1_d, r0_d;
  logic        b1_d, b0_d;

  assign n28_d = {1'b0, num_q};
  assign d1_d  = {2'b00, den_q};
  assign d2_d  = {1'b0, den_q, 1'b0};
  assign d4_d  = {den_q, 2'b00};
  assign b1_d  = n28_d >= d2_d;
  assign r1_d  = b1_d ? n28_d - d2_d : n28_d;
  assign b0_d  = r1_d >= d1_d;
  assign r0_d  = b0_d ? r1_d - d1_d : r1_d;

  always_ff @(posedge clk_i) begin
    if (adv) begin
      sat_q[1]     <= n28_d >= d4_d;
      div_rem_q[1] <= r0_d[DEN_W-1:0];
      div_quo_q[1] <= {30'd0, b1_d, b0_d};
    end
  end

  // Stages 2..16: fraction bits of the ratio
  for (genvar k = 2; k <= 16; k++) begin : g_div
    logic [DEN_W:0] s1_d, s2_d;
    assign s1_d = div_step(div_rem_q[k-1], den_q);
    assign s2_d = div_step(s1_d[DEN_W:1], den_q);
    always_ff @(posedge clk_i) begin
      if (adv) begin
        sat_q[k]     <= sat_q[k-1];
        div_rem_q[k] <= s2_d[DEN_W:1];
        div_quo_q[k] <= {div_quo_q[k-1][29:0], s1_d[0], s2_d[0]};
      end
    end
  end

  // Stages 17..24: square root, two result bits per stage
  logic [31:0] sq_q      [17:24];
  logic [18:0] sq_rem_q  [17:24];
  logic [15:0] sq_root_q [17:24];

  for (genvar j = 17; j <= 24; j++) begin : g_sqrt
    logic [31:0] q_in_d;
    logic [18:0] rem_in_d;
    logic [15:0] root_in_d;
    logic        sat_in_d;
    logic [34:0] t1_d, t2_d;
    if (j == 17) begin : g_first
      assign q_in_d    = div_quo_q[16];
      assign rem_in_d  = '0;
      assign root_in_d = '0;
      assign sat_in_d  = sat_q[16];
    end else begin : g_next
      assign q_in_d    = sq_q[j-1];
      assign rem_in_d  = sq_rem_q[j-1];
      assign root_in_d = sq_root_q[j-1];
      assign sat_in_d  = sat_q[j-1];
    end
    assign t1_d = sq_step(rem_in_d, root_in_d, q_in_d[31-4*(j-17) -: 2]);
    assign t2_d = sq_step(t1_d[34:16], t1_d[15:0], q_in_d[29-4*(j-17) -: 2]);
    always_ff @(posedge clk_i) begin
      if (adv) begin
        sat_q[j]     <= sat_in_d;
        sq_q[j]      <= q_in_d;
        sq_rem_q[j]  <= t2_d[34:16];
        sq_root_q[j] <= t2_d[15:0];
      end
    end
  end

  // Stage 25: classify distance against the radii
  logic        lo_q     [25:34];
  logic        hi_q     [25:34];
  logic [15:0] tr_rem_q [25:33];
  logic [15:0] tr_quo_q [26:33];
  logic [15:0] dist_d;

  assign dist_d = sat_q[24] ? 16'hFFFF : sq_root_q[24];

  always_ff @(posedge clk_i) begin
    if (adv) begin
      lo_q[25]     <= dist_d <= inner_q;
      hi_q[25]     <= dist_d >= outer_q;
      tr_rem_q[25] <= dist_d - inner_q;
    end
  end

  // Stages 26..33: ramp position, sixteen quotient bits
  for (genvar m = 26; m <= 33; m++) begin : g_tdiv
    logic [DEN_W:0]  u1_d, u2_d;
    logic [15:0]     quo_in_d;
    if (m == 26) begin : g_first
      assign quo_in_d = '0;
    end else begin : g_next
      assign quo_in_d = tr_quo_q[m-1];
    end
    assign u1_d = div_step({10'd0, tr_rem_q[m-1]}, {10'd0, dif_q});
    assign u2_d = div_step(u1_d[DEN_W:1], {10'd0, dif_q});
    always_ff @(posedge clk_i) begin
      if (adv) begin
        lo_q[m]     <= lo_q[m-1];
        hi_q[m]     <= hi_q[m-1];
        tr_rem_q[m] <= u2_d[16:1];
        tr_quo_q[m] <= {quo_in_d[13:0], u1_d[0], u2_d[0]};
      end
    end
  end

  // Stage 34..35: smoothstep weight
  logic [14:0] t_q, t2_q;
  logic [14:0] t_d;
  logic [29:0] tsq_d;
  logic [15:0] w35_q;
  logic [31:0] wp_d;

  assign t_d   = tr_quo_q[33][15:1];
  assign tsq_d = {15'd0, t_d} * {15'd0, t_d};
  assign wp_d  = {17'd0, t2_q} * {15'd0, SMOOTH_3 - {1'b0, t_q, 1'b0}};

  always_ff @(posedge clk_i) begin
    if (adv) begin
      lo_q[34] <= lo_q[33];
      hi_q[34] <= hi_q[33];
      t_q      <= t_d;
      t2_q     <= tsq_d[29:15];
      if (lo_q[34]) begin
        w35_q <= '0;
      end else if (hi_q[34]) begin
        w35_q <= W_FULL;
      end else begin
        w35_q <= wp_d[30:15];
      end
    end
  end

  // Stages 36..38: gain and channel scaling
  logic [22:0] g36_q;
  logic signed [24:0] aw_d;
  logic [38:0] p37_q [3];
  logic [48:0] z38_q [3];

  assign aw_d = $signed({{17{amtc_q[7]}}, amtc_q}) * $signed({9'd0, w35_q});

  always_ff @(posedge clk_i) begin
    if (adv) begin
      g36_q <= 23'($signed({2'b00, GAIN_ONE}) + aw_d);
      p37_q[0] <= {23'd0, rgb_q[36].red}   * {16'd0, g36_q};
      p37_q[1] <= {23'd0, rgb_q[36].green} * {16'd0, g36_q};
      p37_q[2] <= {23'd0, rgb_q[36].blue}  * {16'd0, g36_q};
      for (int c = 0; c < 3; c++) begin
        z38_q[c] <= {25'd0, p37_q[c][38:15]} * {24'd0, RECIP_100};
      end
    end
  end

  // Stage 39: saturate and select bypass
  rgb_t out_q;
  logic [17:0] v_d [3];
  logic [CHAN_W-1:0] s_d [3];

  always_comb begin
    for (int c = 0; c < 3; c++) begin
      v_d[c] = z38_q[c][48:31];
      s_d[c] = (v_d[c] > 18'h0FFFF) ? 16'hFFFF : v_d[c][15:0];
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      if (byp_q[NS-2]) begin
        out_q <= rgb_q[NS-2];
      end else begin
        out_q <= '{blue: s_d[2], green: s_d[1], red: s_d[0]};
      end
    end
  end

  assign m_axis_tdata = out_q;

  a_ready_rule: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tready == (!m_axis_tvalid || m_axis_tready))
    else $error("ready does not follow output stall");

  a_div_rem: assert property (@(posedge clk_i) disable iff (!rst_ni)
    vld_q[16] && !byp_q[16] && !sat_q[16] |-> div_rem_q[16] < den_q)
    else $error("distance divide remainder out of range");

  a_weight: assert property (@(posedge clk_i) disable iff (!rst_ni)
    vld_q[35] |-> w35_q <= W_FULL)
    else $error("weight above full scale");

  a_unity: assert property (@(posedge clk_i) disable iff (!rst_ni)
    vld_q[36] && amtc_q == 8'sd0 |-> g36_q == GAIN_ONE)
    else $error("zero amount gives gain other than one");

endmodule
`default_nettype wire
